>>> rtl/ctlc_pkg.sv
//------------------------------------------------------------------------------
// ctlc_pkg
// Shared types, codes and frame formatting for the logic capture unit.
//------------------------------------------------------------------------------
`default_nettype none

package ctlc_pkg;

   localparam int unsigned SAMPLE_DEPTH_DEFAULT = 16;

   localparam int unsigned PIN_W   = 8;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned ENTRY_W = PIN_W + STAMP_W;

   // request opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_RX   = 1'b1;

   // frame characters
   localparam logic [7:0] CH_START = 8'h40;   // '@'
   localparam logic [7:0] CH_END   = 8'h3B;   // ';'
   localparam logic [7:0] CH_GO    = 8'h47;   // 'G'

   // byte positions within one frame
   localparam logic [2:0] POS_START = 3'd0;
   localparam logic [2:0] POS_PIN   = 3'd1;
   localparam logic [2:0] POS_T3    = 3'd2;
   localparam logic [2:0] POS_T2    = 3'd3;
   localparam logic [2:0] POS_T1    = 3'd4;
   localparam logic [2:0] POS_T0    = 3'd5;
   localparam logic [2:0] POS_END   = 3'd6;

   typedef enum logic [1:0] {
      MODE_MONITOR  = 2'd0,
      MODE_SAMPLING = 2'd1,
      MODE_SENDING  = 2'd2,
      MODE_IDLE     = 2'd3
   } mode_type;

   // sequencer to datapath: dump read command and status
   typedef struct packed {
      logic       sending;
      logic       rd_en;
      logic [2:0] byte_pos;
      logic       frame_last;
      logic       dump_last;
   } seq_cmd_type;

   function automatic logic [7:0] frame_byte(input logic [2:0]         pos,
                                             input logic [PIN_W-1:0]   pin,
                                             input logic [STAMP_W-1:0] stamp);
      logic [7:0] b;
      case (pos)
         POS_START: b = CH_START;
         POS_PIN:   b = pin;
         POS_T3:    b = stamp[31:24];
         POS_T2:    b = stamp[23:16];
         POS_T1:    b = stamp[15:8];
         POS_T0:    b = stamp[7:0];
         default:   b = CH_END;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ctlc_sample_mem.sv
//------------------------------------------------------------------------------
// ctlc_sample_mem
// Capture buffer: pin value and timestamp per slot, one write and one
// registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module ctlc_sample_mem #(
   parameter int unsigned DEPTH = ctlc_pkg::SAMPLE_DEPTH_DEFAULT,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [ctlc_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [ctlc_pkg::ENTRY_W-1:0] rd_data
);

   logic [ctlc_pkg::ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ctlc_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/ctlc_seq.sv
//------------------------------------------------------------------------------
// ctlc_seq
// Mode sequencer: change detection, timestamp, buffer fill and dump walk.
//------------------------------------------------------------------------------
`default_nettype none

module ctlc_seq #(
   parameter int unsigned DEPTH = ctlc_pkg::SAMPLE_DEPTH_DEFAULT,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         op,
   input  wire logic [7:0]                   port_value,
   input  wire logic [7:0]                   rx_byte,
   output logic                              wr_en,
   output logic      [AW-1:0]                wr_addr,
   output logic      [ctlc_pkg::ENTRY_W-1:0] wr_data,
   output logic      [AW-1:0]                rd_addr,
   output ctlc_pkg::seq_cmd_type             cmd
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   ctlc_pkg::mode_type mode_ff, mode_in;
   logic [7:0]         last_ff, last_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [31:0]        time_ff, time_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [2:0]         pos_ff,  pos_in;

   logic [CW-1:0]      fill_nxt;
   logic               frame_end;
   logic               dump_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ctlc_pkg::MODE_SAMPLING;
         last_ff <= '0;
         fill_ff <= '0;
         time_ff <= '0;
         slot_ff <= '0;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         last_ff <= last_in;
         fill_ff <= fill_in;
         time_ff <= time_in;
         slot_ff <= slot_in;
         pos_ff  <= pos_in;
      end
   end

   assign fill_nxt  = (fill_ff < CW'(DEPTH)) ? fill_ff + CW'(1) : fill_ff;
   assign frame_end = (pos_ff == ctlc_pkg::POS_END);
   assign dump_end  = frame_end && (slot_ff == AW'(DEPTH - 1));

   assign wr_addr = fill_ff[AW-1:0];
   assign wr_data = {last_ff, time_ff};
   assign rd_addr = slot_ff;

   always_comb begin
      mode_in = mode_ff;
      last_in = last_ff;
      fill_in = fill_ff;
      time_in = time_ff;
      slot_in = slot_ff;
      pos_in  = pos_ff;
      wr_en   = 1'b0;

      cmd            = '0;
      cmd.sending    = (mode_ff == ctlc_pkg::MODE_SENDING);
      cmd.byte_pos   = pos_ff;
      cmd.frame_last = frame_end;
      cmd.dump_last  = dump_end;

      if (accept) begin
         if (op == ctlc_pkg::OP_RX) begin
            if (mode_ff == ctlc_pkg::MODE_IDLE && rx_byte == ctlc_pkg::CH_GO) begin
               time_in = '0;
               fill_in = '0;
               mode_in = ctlc_pkg::MODE_MONITOR;
            end
         end else begin
            time_in = time_ff + 32'd1;
            case (mode_ff)
               ctlc_pkg::MODE_MONITOR: begin
                  last_in = port_value;
                  if (port_value != last_ff) begin
                     mode_in = ctlc_pkg::MODE_SAMPLING;
                  end
               end
               ctlc_pkg::MODE_SAMPLING: begin
                  wr_en   = (fill_ff < CW'(DEPTH));
                  fill_in = fill_nxt;
                  if (fill_nxt >= CW'(DEPTH)) begin
                     mode_in = ctlc_pkg::MODE_SENDING;
                     slot_in = '0;
                     pos_in  = '0;
                  end else begin
                     mode_in = ctlc_pkg::MODE_MONITOR;
                  end
               end
               ctlc_pkg::MODE_SENDING: begin
                  cmd.rd_en = 1'b1;
                  if (frame_end) begin
                     pos_in = '0;
                     if (dump_end) begin
                        slot_in = '0;
                        fill_in = '0;
                        mode_in = ctlc_pkg::MODE_IDLE;
                     end else begin
                        slot_in = slot_ff + AW'(1);
                     end
                  end else begin
                     pos_in = pos_ff + 3'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/change_triggered_logic_capture_unit.sv
//------------------------------------------------------------------------------
// change_triggered_logic_capture_unit
// 8-bit change-triggered logic capture with a framed byte dump.
//------------------------------------------------------------------------------
// Channel | Ports                                       | Dir
// request | req_valid req_stall req_op req_port_value   | in
//         | req_rx_byte                                 |
// response| rsp_valid rsp_stall rsp_tx_byte             | out
//         | rsp_frame_last rsp_dump_last                |
//
// Ticks outside the dump and received bytes need no buffer read.
// A dump tick holds off the next request while its buffer read is pending:
// the buffer read is registered, and the response register loads the cycle after it.
// A dump tick waits while a previous response is still held by rsp_stall.
// Synchronous reset; the buffer needs no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none

module change_triggered_logic_capture_unit #(
   parameter int unsigned SAMPLE_DEPTH = ctlc_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_port_value,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_tx_byte,
   output logic            rsp_frame_last,
   output logic            rsp_dump_last
);

   localparam int unsigned AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

   logic                          accept;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [ctlc_pkg::ENTRY_W-1:0]  wr_data;
   logic [AW-1:0]                 rd_addr;
   logic [ctlc_pkg::ENTRY_W-1:0]  rd_data;
   ctlc_pkg::seq_cmd_type         cmd;

   logic       pend_ff,  pend_in;
   logic [2:0] pos_ff;
   logic       frame_ff;
   logic       dump_ff;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       flast_ff;
   logic       dlast_ff;

   assign req_stall = pend_ff | (valid_ff & rsp_stall & cmd.sending);
   assign accept    = req_valid & ~req_stall;

   ctlc_seq #(
      .DEPTH (SAMPLE_DEPTH),
      .AW    (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_op),
      .port_value (req_port_value),
      .rx_byte    (req_rx_byte),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .cmd        (cmd)
   );

   ctlc_sample_mem #(
      .DEPTH (SAMPLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pend_in  = cmd.rd_en;
   assign valid_in = pend_ff | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // read metadata travels alongside the buffer read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         pos_ff   <= cmd.byte_pos;
         frame_ff <= cmd.frame_last;
         dump_ff  <= cmd.dump_last;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         byte_ff  <= ctlc_pkg::frame_byte(pos_ff,
                        rd_data[ctlc_pkg::ENTRY_W-1:ctlc_pkg::STAMP_W],
                        rd_data[ctlc_pkg::STAMP_W-1:0]);
         flast_ff <= frame_ff;
         dlast_ff <= dump_ff;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_tx_byte    = byte_ff;
   assign rsp_frame_last = flast_ff;
   assign rsp_dump_last  = dlast_ff;

endmodule

`default_nettype wire

>>> tb/tb_change_triggered_logic_capture_unit.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_change_triggered_logic_capture_unit
// Self-checking bench for the change-triggered logic capture unit. Port
// samples and serial bytes are driven with random gaps. The dump bytes are
// taken under random stall and checked in order against a cycle-free model of
// the capture, fill, dump and restart sequence.
//------------------------------------------------------------------------------
`default_nettype none

module tb_change_triggered_logic_capture_unit;

   localparam int unsigned DEPTH       = ctlc_pkg::SAMPLE_DEPTH_DEFAULT;
   localparam int unsigned ITEMS       = 1300;
   localparam int unsigned QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_last;
      logic       dump_last;
   } dump_byte_type;

   class capture_scoreboard;
      ctlc_pkg::mode_type mode;
      logic [7:0]    last_port;
      int unsigned   fill_count;
      logic [31:0]   tick_time;
      logic [7:0]    pin_store [DEPTH];
      logic [31:0]   stamp_store [DEPTH];
      int unsigned   send_slot;
      logic [2:0]    send_pos;
      dump_byte_type dump_bytes[$];
      int unsigned   errors;

      function new();
         mode       = ctlc_pkg::MODE_SAMPLING;
         last_port  = 8'h00;
         fill_count = 0;
         tick_time  = 32'h0;
         send_slot  = 0;
         send_pos   = ctlc_pkg::POS_START;
         errors     = 0;
         foreach (pin_store[i]) begin
            pin_store[i]   = 8'h00;
            stamp_store[i] = 32'h0;
         end
      endfunction

      // advance the capture state by one accepted request
      function void note_request(logic op, logic [7:0] port_value, logic [7:0] rx_byte);
         logic [31:0]   now;
         dump_byte_type b;
         if (op == ctlc_pkg::OP_RX) begin
            if (mode == ctlc_pkg::MODE_IDLE && rx_byte == ctlc_pkg::CH_GO) begin
               tick_time  = 32'h0;
               fill_count = 0;
               mode       = ctlc_pkg::MODE_MONITOR;
               foreach (pin_store[i]) begin
                  pin_store[i]   = 8'h00;
                  stamp_store[i] = 32'h0;
               end
            end
            return;
         end
         now       = tick_time;
         tick_time = tick_time + 32'd1;
         case (mode)
            ctlc_pkg::MODE_MONITOR: begin
               if (last_port != port_value)
                  mode = ctlc_pkg::MODE_SAMPLING;
               last_port = port_value;
            end
            ctlc_pkg::MODE_SAMPLING: begin
               if (fill_count < DEPTH) begin
                  pin_store[fill_count]   = last_port;
                  stamp_store[fill_count] = now;
                  fill_count++;
               end
               if (fill_count >= DEPTH) begin
                  mode      = ctlc_pkg::MODE_SENDING;
                  send_slot = 0;
                  send_pos  = ctlc_pkg::POS_START;
               end else begin
                  mode = ctlc_pkg::MODE_MONITOR;
               end
            end
            ctlc_pkg::MODE_SENDING: begin
               b.frame_last = (send_pos >= ctlc_pkg::POS_END);
               b.dump_last  = b.frame_last && (send_slot + 1 >= DEPTH);
               case (send_pos)
                  ctlc_pkg::POS_START: b.tx_byte = ctlc_pkg::CH_START;
                  ctlc_pkg::POS_PIN:   b.tx_byte = pin_store[send_slot];
                  ctlc_pkg::POS_T3:    b.tx_byte = stamp_store[send_slot][31:24];
                  ctlc_pkg::POS_T2:    b.tx_byte = stamp_store[send_slot][23:16];
                  ctlc_pkg::POS_T1:    b.tx_byte = stamp_store[send_slot][15:8];
                  ctlc_pkg::POS_T0:    b.tx_byte = stamp_store[send_slot][7:0];
                  default:             b.tx_byte = ctlc_pkg::CH_END;
               endcase
               dump_bytes.push_back(b);
               if (b.frame_last) begin
                  send_pos = ctlc_pkg::POS_START;
                  if (b.dump_last) begin
                     send_slot  = 0;
                     fill_count = 0;
                     mode       = ctlc_pkg::MODE_IDLE;
                  end else begin
                     send_slot++;
                  end
               end else begin
                  send_pos++;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_byte(logic [7:0] tx_byte, logic frame_last, logic dump_last);
         dump_byte_type e;
         if (dump_bytes.size() == 0) begin
            $display("%0t: unexpected dump byte %02h frame_last %b dump_last %b",
                     $time, tx_byte, frame_last, dump_last);
            errors++;
            return;
         end
         e = dump_bytes.pop_front();
         if (tx_byte !== e.tx_byte) begin
            $display("%0t: tx_byte expected %02h got %02h", $time, e.tx_byte, tx_byte);
            errors++;
         end
         if (frame_last !== e.frame_last) begin
            $display("%0t: frame_last expected %b got %b", $time, e.frame_last, frame_last);
            errors++;
         end
         if (dump_last !== e.dump_last) begin
            $display("%0t: dump_last expected %b got %b", $time, e.dump_last, dump_last);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_op         = ctlc_pkg::OP_TICK;
   logic [7:0] req_port_value = 8'h00;
   logic [7:0] req_rx_byte    = 8'h00;
   logic       rsp_stall      = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   wire  [7:0] rsp_tx_byte;
   wire        rsp_frame_last;
   wire        rsp_dump_last;

   capture_scoreboard capture = new();

   bit          gap_burst   = 1'b0;
   bit          stall_burst = 1'b0;
   int unsigned stall_left  = 0;
   int unsigned quiet_cycles = 0;

   change_triggered_logic_capture_unit #(
      .SAMPLE_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_port_value (req_port_value),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_dump_last  (rsp_dump_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // called at a rising edge; returns at the edge the request is accepted
   task automatic send_request(input logic op, input logic [7:0] port_value,
                               input logic [7:0] rx_byte);
      int unsigned gap;
      if ($urandom_range(0, 99) == 0)
         gap_burst = ~gap_burst;
      gap = gap_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_port_value <= port_value;
      req_rx_byte    <= rx_byte;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      capture.note_request(op, port_value, rx_byte);
   endtask

   task automatic tick(input logic [7:0] port_value);
      send_request(ctlc_pkg::OP_TICK, port_value, 8'($urandom_range(0, 255)));
   endtask

   task automatic receive(input logic [7:0] rx_byte);
      send_request(ctlc_pkg::OP_RX, 8'($urandom_range(0, 255)), rx_byte);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            capture.check_byte(rsp_tx_byte, rsp_frame_last, rsp_dump_last);
            if ($urandom_range(0, 63) == 0)
               stall_burst = ~stall_burst;
            stall_left = stall_burst ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_change_triggered_logic_capture_unit: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned        counted;
      int unsigned        r;
      ctlc_pkg::mode_type m;
      logic               op;
      logic [7:0]         pv;
      logic [7:0]         rx;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bytes outside idle are dropped; first tick after reset stores pin 0 at time 0
      receive(ctlc_pkg::CH_GO);
      receive(8'h00);
      receive(8'hFF);
      tick(8'hFF);
      tick(8'hFF);
      // stored pin is the latched trigger value, not this tick's sample
      tick(8'h00);
      tick(8'hFF);
      tick(8'h00);
      receive(ctlc_pkg::CH_GO);
      tick(8'h5A);
      tick(8'hA5);
      tick(8'hA5);
      tick(8'hA5);
      tick(8'h00);
      receive(8'h55);
      tick(8'hAA);

      counted = 0;
      while (counted < ITEMS) begin
         m  = capture.mode;
         pv = 8'($urandom_range(0, 255));
         rx = 8'($urandom_range(0, 255));
         if (m == ctlc_pkg::MODE_IDLE) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               op = ctlc_pkg::OP_RX;
               rx = ctlc_pkg::CH_GO;
            end else if (r < 7) begin
               op = ctlc_pkg::OP_TICK;
            end else begin
               op = ctlc_pkg::OP_RX;
            end
         end else if ($urandom_range(0, 19) == 0) begin
            op = ctlc_pkg::OP_RX;
            if ($urandom_range(0, 2) == 0)
               rx = ctlc_pkg::CH_GO;
         end else begin
            op = ctlc_pkg::OP_TICK;
            if ($urandom_range(0, 1) == 0)
               pv = capture.last_port;
         end
         send_request(op, pv, rx);
         if (op == ctlc_pkg::OP_TICK || (m == ctlc_pkg::MODE_IDLE && rx == ctlc_pkg::CH_GO))
            counted++;
      end
      req_valid <= 1'b0;

      while (capture.dump_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (capture.errors == 0 && capture.dump_bytes.size() == 0)
         $display("tb_change_triggered_logic_capture_unit: done, clean");
      else
         $display("tb_change_triggered_logic_capture_unit: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
